>>> hw/rtl/cwra_pkg.sv
// Package for the cascaded windowed rate average block.
// Holds the sequencer state codes; used by the top level.
package cwra_pkg;
   localparam int STATE_BITS = 4;
   localparam logic [STATE_BITS-1:0] ST_IDLE   = 4'd0;
   localparam logic [STATE_BITS-1:0] ST_SUM    = 4'd1;
   localparam logic [STATE_BITS-1:0] ST_DIV    = 4'd2;
   localparam logic [STATE_BITS-1:0] ST_LATCH  = 4'd3;
   localparam logic [STATE_BITS-1:0] ST_BLEND  = 4'd4;
   localparam logic [STATE_BITS-1:0] ST_BDIV   = 4'd5;
   localparam logic [STATE_BITS-1:0] ST_WRITE  = 4'd6;
   localparam logic [STATE_BITS-1:0] ST_OUT    = 4'd7;
   localparam logic [STATE_BITS-1:0] ST_LWAIT  = 4'd8;
   localparam logic [STATE_BITS-1:0] ST_SWAIT  = 4'd9;
endpackage

>>> hw/rtl/cwra_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module cwra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/cascaded_windowed_rate_average.sv
// Cascaded windowed rate average: short, medium and long ring averages.
// Uses cwra_pkg and cwra_ram (one RAM holds all three rings).
//
// Usage:
//   req_tdata carries one rate sample (8 fraction bits). rsp_tdata returns
//   short, medium and long averages for each request transaction.
//   One item in the sequencer at a time: req_tready is high only while idle.
//   Each ring level runs a sum sweep over its slots (one RAM read per cycle)
//   and a restoring division by the filled count. Medium and long levels
//   blend with the latched slot, when it was filled, through a reciprocal
//   multiply in 16-bit chunks. The next request is accepted at the edge after
//   rsp_tvalid rises.
//   A zero sample leaves the state unchanged and returns current averages.
//   Reset clears poll position, filled masks and latches; RAM contents are
//   ignored until written. When rsp_tready is low the result holds in the
//   output register; one more item is processed and waits for that register,
//   and the input stalls until the result is taken.
module cascaded_windowed_rate_average #(
   parameter int SHORT_SLOTS  = 12,
   parameter int MEDIUM_SLOTS = 10,
   parameter int LONG_SLOTS   = 6,
   parameter int SAMPLE_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] rate_sample
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata    // [31:0] short, [63:32] medium, [95:64] long
);
   localparam int LONG_PERIOD = SHORT_SLOTS * MEDIUM_SLOTS;
   localparam int POLL_WRAP   = LONG_PERIOD * LONG_SLOTS;
   localparam int PB          = $clog2(POLL_WRAP);
   localparam int DEPTH       = SHORT_SLOTS + MEDIUM_SLOTS + LONG_SLOTS;
   localparam int AB          = $clog2(DEPTH);
   localparam int SUMB        = SAMPLE_BITS + 7;
   localparam int CB          = 7;
   localparam int LPB         = $clog2(LONG_PERIOD + 1);
   localparam int NUMB        = SAMPLE_BITS + 2 * LPB + 1;
   localparam int DIVB        = (NUMB > SUMB) ? NUMB : SUMB;
   localparam int DCB         = $clog2(DIVB + 1);
   localparam int MAXS        = 64;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_ZERO = '0;
   // blend numerator bits, reciprocal shift and chunked multiply sizes
   localparam int XB          = SAMPLE_BITS + LPB;
   localparam int KB          = SAMPLE_BITS + 2 * LPB;
   localparam int MCW         = 16;
   localparam int MCN         = (KB + MCW - 1) / MCW;
   localparam int MNB         = $clog2(MCN);
   localparam int RB          = MCN * MCW;
   localparam int ACCB        = XB + RB;
   // ceil(2^KB / D): exact floor division for numerators below 2^XB
   localparam logic [RB-1:0] RCP_MED =
      RB'(((128'd1 << KB) + 128'(SHORT_SLOTS - 1)) / 128'(SHORT_SLOTS));
   localparam logic [RB-1:0] RCP_LONG =
      RB'(((128'd1 << KB) + 128'(LONG_PERIOD - 1)) / 128'(LONG_PERIOD));

   logic [cwra_pkg::STATE_BITS-1:0] state_ff, state_in;
   logic [PB-1:0]  pos_ff, pos_in;
   logic [7:0]     s_slot_ff, s_slot_in, m_slot_ff, m_slot_in, l_slot_ff, l_slot_in;
   logic [LPB-1:0] l_phase_ff, l_phase_in;
   logic [MAXS-1:0] s_fill_ff, s_fill_in, m_fill_ff, m_fill_in, l_fill_ff, l_fill_in;
   logic [SAMPLE_BITS-1:0] m_lat_ff, m_lat_in, l_lat_ff, l_lat_in;
   logic m_latv_ff, m_latv_in, l_latv_ff, l_latv_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic upd_ff, upd_in;
   logic [1:0] lvl_ff, lvl_in;
   logic [7:0] idx_ff, idx_in;
   logic rdv_ff, rdv_in;
   logic [SUMB-1:0] sum_ff, sum_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [DIVB-1:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DCB-1:0] dcnt_ff, dcnt_in;
   logic [ACCB-1:0] acc_ff, acc_in;
   logic [MNB-1:0] mcnt_ff, mcnt_in;
   logic [SAMPLE_BITS-1:0] avg_ff [3];
   logic [SAMPLE_BITS-1:0] avg_in [3];
   logic rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [SAMPLE_BITS-1:0] req_sample;

   logic wr_en;
   logic [AB-1:0] wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0] wr_data, rd_data;

   cwra_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // per-level view
   logic [7:0] lv_slots, lv_base, lv_slot;
   logic [MAXS-1:0] lv_fill;
   logic [LPB-1:0] lv_phase, lv_period;
   logic [SAMPLE_BITS-1:0] lv_lat;
   logic lv_latv;
   logic [RB-1:0] lv_rcp;
   logic [DIVB:0] trial;
   logic [XB+MCW-1:0] prod;

   always_comb begin
      unique case (lvl_ff)
         2'd0: begin
            lv_slots = 8'(SHORT_SLOTS); lv_base = 8'd0; lv_slot = s_slot_ff;
            lv_fill = s_fill_ff; lv_phase = '0; lv_period = LPB'(1);
            lv_lat = m_lat_ff; lv_latv = 1'b0; lv_rcp = RCP_MED;
         end
         2'd1: begin
            lv_slots = 8'(MEDIUM_SLOTS); lv_base = 8'(SHORT_SLOTS); lv_slot = m_slot_ff;
            lv_fill = m_fill_ff; lv_phase = LPB'(s_slot_ff);
            lv_period = LPB'(SHORT_SLOTS); lv_lat = m_lat_ff; lv_latv = m_latv_ff;
            lv_rcp = RCP_MED;
         end
         default: begin
            lv_slots = 8'(LONG_SLOTS); lv_base = 8'(SHORT_SLOTS + MEDIUM_SLOTS);
            lv_slot = l_slot_ff; lv_fill = l_fill_ff; lv_phase = l_phase_ff;
            lv_period = LPB'(LONG_PERIOD); lv_lat = l_lat_ff; lv_latv = l_latv_ff;
            lv_rcp = RCP_LONG;
         end
      endcase
   end

   assign trial = {rem_ff, quo_ff[DIVB-1]} - {1'b0, dsr_ff};
   // one chunk of the reciprocal per cycle, most significant chunk first
   assign prod = {{MCW{1'b0}}, quo_ff[XB-1:0]} * {{XB{1'b0}}, lv_rcp[mcnt_ff*MCW +: MCW]};
   assign req_sample = SAMPLE_BITS'(req_tdata);

   always_comb begin
      state_in = state_ff; pos_in = pos_ff;
      s_slot_in = s_slot_ff; m_slot_in = m_slot_ff; l_slot_in = l_slot_ff;
      l_phase_in = l_phase_ff;
      s_fill_in = s_fill_ff; m_fill_in = m_fill_ff; l_fill_in = l_fill_ff;
      m_lat_in = m_lat_ff; l_lat_in = l_lat_ff; m_latv_in = m_latv_ff; l_latv_in = l_latv_ff;
      sample_in = sample_ff; upd_in = upd_ff; lvl_in = lvl_ff; idx_in = idx_ff;
      rdv_in = 1'b0; sum_in = sum_ff; cnt_in = cnt_ff;
      quo_in = quo_ff; rem_in = rem_ff; dsr_in = dsr_ff; dcnt_in = dcnt_ff;
      acc_in = acc_ff; mcnt_in = mcnt_ff;
      avg_in = avg_ff; rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      wr_en = 1'b0; wr_addr = AB'(lv_base + lv_slot); wr_data = sample_ff;
      rd_addr = AB'(lv_base + idx_ff);
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         cwra_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_sample;
               upd_in = (req_sample != SAMPLE_ZERO);
               lvl_in = 2'd0;
               state_in = (req_sample != SAMPLE_ZERO) ?
                          cwra_pkg::ST_WRITE : cwra_pkg::ST_SUM;
               idx_in = '0; sum_in = '0; cnt_in = '0;
            end
         end
         cwra_pkg::ST_WRITE: begin
            // sample_ff holds the value to store for the current level
            wr_en = 1'b1;
            unique case (lvl_ff)
               2'd0: s_fill_in[s_slot_ff[5:0]] = 1'b1;
               2'd1: m_fill_in[m_slot_ff[5:0]] = 1'b1;
               default: l_fill_in[l_slot_ff[5:0]] = 1'b1;
            endcase
            idx_in = '0; sum_in = '0; cnt_in = '0;
            state_in = cwra_pkg::ST_SUM;
         end
         cwra_pkg::ST_SUM: begin
            // one read issued per cycle; accumulate the previous read
            if (rdv_ff && lv_fill[idx_ff[5:0] - 6'd1]) begin
               sum_in = sum_ff + SUMB'(rd_data);
               cnt_in = cnt_ff + CB'(1);
            end
            if (idx_ff == lv_slots) begin
               state_in = cwra_pkg::ST_DIV;
               quo_in = DIVB'(sum_in); rem_in = '0;
               dsr_in = DIVB'(cnt_in); dcnt_in = DCB'(DIVB);
            end else begin
               rdv_in = 1'b1;
               idx_in = idx_ff + 8'd1;
            end
         end
         cwra_pkg::ST_DIV: begin
            if (dcnt_ff == '0) begin
               // count zero gives an all-ones quotient; mask to zero
               avg_in[lvl_ff] = (dsr_ff == '0) ? '0 : quo_ff[SAMPLE_BITS-1:0];
               if (!upd_ff || lvl_ff == 2'd2) begin
                  if (lvl_ff == 2'd2 || !upd_ff) state_in = cwra_pkg::ST_OUT;
                  if (!upd_ff && lvl_ff != 2'd2) begin
                     lvl_in = lvl_ff + 2'd1; idx_in = '0; sum_in = '0; cnt_in = '0;
                     state_in = cwra_pkg::ST_SUM;
                  end
               end else begin
                  lvl_in = lvl_ff + 2'd1;
                  sample_in = (dsr_ff == '0) ? '0 : quo_ff[SAMPLE_BITS-1:0];
                  state_in = cwra_pkg::ST_LATCH;
               end
            end else begin
               dcnt_in = dcnt_ff - DCB'(1);
               if (!trial[DIVB]) begin
                  rem_in = trial[DIVB-1:0];
                  quo_in = {quo_ff[DIVB-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[DIVB-2:0], quo_ff[DIVB-1]};
                  quo_in = {quo_ff[DIVB-2:0], 1'b0};
               end
            end
         end
         cwra_pkg::ST_BDIV: begin
            acc_in = (acc_ff << MCW) + ACCB'(prod);
            if (mcnt_ff == '0) begin
               sample_in = acc_in[KB +: SAMPLE_BITS];
               state_in = cwra_pkg::ST_WRITE;
            end else begin
               mcnt_in = mcnt_ff - MNB'(1);
            end
         end
         cwra_pkg::ST_LATCH: begin
            // read old slot content at phase zero
            rd_addr = AB'(lv_base + lv_slot);
            state_in = (lv_phase == '0) ? cwra_pkg::ST_LWAIT : cwra_pkg::ST_BLEND;
         end
         cwra_pkg::ST_LWAIT: begin
            if (lvl_ff == 2'd1) begin
               m_latv_in = m_fill_ff[m_slot_ff[5:0]];
               m_lat_in = m_fill_ff[m_slot_ff[5:0]] ? rd_data : '0;
            end else begin
               l_latv_in = l_fill_ff[l_slot_ff[5:0]];
               l_lat_in = l_fill_ff[l_slot_ff[5:0]] ? rd_data : '0;
            end
            state_in = cwra_pkg::ST_BLEND;
         end
         cwra_pkg::ST_BLEND: begin
            if (lv_latv) begin
               quo_in = DIVB'(XB'(lv_phase + LPB'(1)) * XB'(sample_ff)
                      + XB'(lv_period - lv_phase - LPB'(1)) * XB'(lv_lat));
               acc_in = '0; mcnt_in = MNB'(MCN - 1);
               state_in = cwra_pkg::ST_BDIV;
            end else begin
               state_in = cwra_pkg::ST_WRITE;
            end
         end
         cwra_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {32'(avg_ff[2]), 32'(avg_ff[1]), 32'(avg_ff[0])};
               if (upd_ff) begin
                  pos_in = (pos_ff == PB'(POLL_WRAP - 1)) ? '0 : pos_ff + PB'(1);
                  s_slot_in = (s_slot_ff == 8'(SHORT_SLOTS - 1)) ? '0 : s_slot_ff + 8'd1;
                  if (s_slot_ff == 8'(SHORT_SLOTS - 1))
                     m_slot_in = (m_slot_ff == 8'(MEDIUM_SLOTS - 1)) ? '0 : m_slot_ff + 8'd1;
                  l_phase_in = (l_phase_ff == LPB'(LONG_PERIOD - 1)) ? '0 :
                               l_phase_ff + LPB'(1);
                  if (l_phase_ff == LPB'(LONG_PERIOD - 1))
                     l_slot_in = (l_slot_ff == 8'(LONG_SLOTS - 1)) ? '0 : l_slot_ff + 8'd1;
               end
               state_in = cwra_pkg::ST_IDLE;
            end
         end
         default: state_in = cwra_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwra_pkg::ST_IDLE; pos_ff <= '0;
         s_slot_ff <= '0; m_slot_ff <= '0; l_slot_ff <= '0; l_phase_ff <= '0;
         s_fill_ff <= '0; m_fill_ff <= '0; l_fill_ff <= '0;
         m_lat_ff <= '0; l_lat_ff <= '0; m_latv_ff <= 1'b0; l_latv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in;
         s_slot_ff <= s_slot_in; m_slot_ff <= m_slot_in; l_slot_ff <= l_slot_in;
         l_phase_ff <= l_phase_in;
         s_fill_ff <= s_fill_in; m_fill_ff <= m_fill_in; l_fill_ff <= l_fill_in;
         m_lat_ff <= m_lat_in; l_lat_ff <= l_lat_in;
         m_latv_ff <= m_latv_in; l_latv_ff <= l_latv_in;
         rsp_valid_ff <= rsp_valid_in; rdv_ff <= rdv_in;
      end
      sample_ff <= sample_in; upd_ff <= upd_in; lvl_ff <= lvl_in; idx_ff <= idx_in;
      sum_ff <= sum_in; cnt_ff <= cnt_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dsr_ff <= dsr_in; dcnt_ff <= dcnt_in;
      acc_ff <= acc_in; mcnt_ff <= mcnt_in;
      avg_ff <= avg_in; rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == cwra_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != cwra_pkg::ST_IDLE |-> !req_tready) else $error("ready while busy");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      pos_ff < PB'(POLL_WRAP)) else $error("poll position out of range");
endmodule

>>> dv/cwra_checker.sv
// Checker for the cascaded windowed rate average block: watches both streams,
// predicts short/medium/long averages per request transaction and compares.
// Standalone; needs the DUT port widths and its default slot counts.
module cwra_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   localparam int SHORT_N  = 12;
   localparam int MEDIUM_N = 10;
   localparam int LONG_N   = 6;
   localparam int LONG_PER = SHORT_N * MEDIUM_N;
   localparam int WRAP     = LONG_PER * LONG_N;

   int unsigned     poll_pos;
   logic [63:0]     short_ring  [SHORT_N];
   logic [63:0]     medium_ring [MEDIUM_N];
   logic [63:0]     long_ring   [LONG_N];
   logic [SHORT_N-1:0]  short_fill;
   logic [MEDIUM_N-1:0] medium_fill;
   logic [LONG_N-1:0]   long_fill;
   logic [63:0]     medium_hold, long_hold;
   logic            medium_hold_ok, long_hold_ok;
   logic [95:0]     avg_queue [$];

   function automatic logic [63:0] mean_of(input logic [63:0] ring [], input int n,
                                           input logic [63:0] fill);
      logic [63:0] sum;
      logic [63:0] cnt;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < n; i++)
         if (fill[i]) begin
            sum += ring[i];
            cnt++;
         end
      return (cnt == 0) ? 64'd0 : sum / cnt;
   endfunction

   function automatic logic [63:0] mix(input logic [63:0] fresh, input logic [63:0] old,
                                       input int unsigned phase, input int unsigned per);
      logic [63:0] wn;
      wn = phase + 1;
      return (wn * fresh + (per - wn) * old) / per;
   endfunction

   task automatic predict_averages(input logic [31:0] sample);
      logic [63:0] s_avg, m_avg, l_avg, v;
      logic [63:0] sr [], mr [], lr [];
      int unsigned s_slot, m_slot, l_phase, l_slot;
      sr = new[SHORT_N];
      mr = new[MEDIUM_N];
      lr = new[LONG_N];
      if (sample != 0) begin
         s_slot  = poll_pos % SHORT_N;
         m_slot  = (poll_pos / SHORT_N) % MEDIUM_N;
         l_phase = poll_pos % LONG_PER;
         l_slot  = (poll_pos / LONG_PER) % LONG_N;
         short_ring[s_slot] = sample;
         short_fill[s_slot] = 1'b1;
         foreach (sr[i]) sr[i] = short_ring[i];
         s_avg = mean_of(sr, SHORT_N, short_fill);
         if (s_slot == 0) begin
            medium_hold_ok = medium_fill[m_slot];
            medium_hold    = medium_hold_ok ? medium_ring[m_slot] : 64'd0;
         end
         v = medium_hold_ok ? mix(s_avg, medium_hold, s_slot, SHORT_N) : s_avg;
         medium_ring[m_slot] = v;
         medium_fill[m_slot] = 1'b1;
         foreach (mr[i]) mr[i] = medium_ring[i];
         m_avg = mean_of(mr, MEDIUM_N, medium_fill);
         if (l_phase == 0) begin
            long_hold_ok = long_fill[l_slot];
            long_hold    = long_hold_ok ? long_ring[l_slot] : 64'd0;
         end
         v = long_hold_ok ? mix(m_avg, long_hold, l_phase, LONG_PER) : m_avg;
         long_ring[l_slot] = v;
         long_fill[l_slot] = 1'b1;
         foreach (lr[i]) lr[i] = long_ring[i];
         l_avg = mean_of(lr, LONG_N, long_fill);
         poll_pos = (poll_pos + 1) % WRAP;
      end else begin
         foreach (sr[i]) sr[i] = short_ring[i];
         foreach (mr[i]) mr[i] = medium_ring[i];
         foreach (lr[i]) lr[i] = long_ring[i];
         s_avg = mean_of(sr, SHORT_N, short_fill);
         m_avg = mean_of(mr, MEDIUM_N, medium_fill);
         l_avg = mean_of(lr, LONG_N, long_fill);
      end
      avg_queue.push_back({l_avg[31:0], m_avg[31:0], s_avg[31:0]});
   endtask

   assign pending = avg_queue.size();

   always @(posedge clock) begin
      logic [95:0] want;
      if (reset) begin
         poll_pos       = 0;
         short_fill     = '0;
         medium_fill    = '0;
         long_fill      = '0;
         medium_hold    = 0;
         long_hold      = 0;
         medium_hold_ok = 1'b0;
         long_hold_ok   = 1'b0;
         foreach (short_ring[i]) short_ring[i] = 0;
         foreach (medium_ring[i]) medium_ring[i] = 0;
         foreach (long_ring[i]) long_ring[i] = 0;
         avg_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (avg_queue.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = avg_queue.pop_front();
               if (want[31:0] !== rsp_tdata[31:0]) begin
                  $display("%0t: short_average expected %0d actual %0d",
                           $time, want[31:0], rsp_tdata[31:0]);
                  fail_count++;
               end
               if (want[63:32] !== rsp_tdata[63:32]) begin
                  $display("%0t: medium_average expected %0d actual %0d",
                           $time, want[63:32], rsp_tdata[63:32]);
                  fail_count++;
               end
               if (want[95:64] !== rsp_tdata[95:64]) begin
                  $display("%0t: long_average expected %0d actual %0d",
                           $time, want[95:64], rsp_tdata[95:64]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_averages(req_tdata);
      end
   end
endmodule

>>> dv/tb_top.sv
// Top of the cascaded windowed rate average testbench: clock, reset, stimulus
// with idle/stall phases and the verdict. Depends on cwra_checker and the DUT.
module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_off = 1'b0;

   cascaded_windowed_rate_average dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   cwra_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // 1413 items plus stalls, with wide margin
   initial begin
      #(12 * 4000000);
      $display("[cascaded_windowed_rate_average] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // tvalid stays high between back-to-back transactions; it drops only when idling
   task automatic send_sample(input logic [31:0] sample);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF - $urandom_range(255);
         2: return 32'd1 << $urandom_range(31);
         3: return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, zero samples before and after filling, single bits
      send_sample(32'd0);
      send_sample(32'd1);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'd0);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h8000_0000);
      for (int b = 0; b < 16; b++) send_sample(32'h1 << (2 * b + (b & 1)));
      send_sample(32'h5555_5555);
      send_sample(32'hAAAA_AAAA);
      send_sample(32'd0);
      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 8; i++) send_sample(pick_sample());
      join
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 18 : 67) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 18 : 67) : 0;
         for (int i = 0; i < 345; i++) send_sample(pick_sample());
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (fail_count == 0) $display("[cascaded_windowed_rate_average] OK");
      else $display("[cascaded_windowed_rate_average] ERROR");
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/cwra_pkg.sv
hw/rtl/cwra_ram.sv
hw/rtl/cascaded_windowed_rate_average.sv
dv/cwra_checker.sv
dv/tb_top.sv
